FILE: sv/ob64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ob64_pkg
// shared types and constants of the offset base64 frame decoder
// ============================================================================
package ob64_pkg;

    // frame length counter saturates here
    localparam int MaxFrameChars = 1024;
    localparam int PosW          = $clog2(MaxFrameChars + 1);

    localparam int SumW     = 12;
    localparam int ChOffset = 61;   // ascii '='

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SUM   = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT = 2'd2;

    typedef struct packed {
        logic [6:0] rx_char;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_out_item;

    // work handed from the front to the back for one character
    typedef struct packed {
        logic       has_bytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       has_status;
        logic [1:0] status;
    } t_job;

endpackage
`default_nettype wire

FILE: sv/offset_base64_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// offset_base64_frame_decoder
// streaming decoder for offset base64 frames with additive checksum
// ============================================================================
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------
//  in      | in  | i_in_valid / o_in_stall    | rx_char, frame_end
//  out     | out | o_out_valid / i_out_stall  | kind, data_byte, status,
//          |     |                            | last_of_run
//
//  one character is taken per cycle while the job queue has room; a character
//  gives zero to four result requests, sent one per cycle from the output
//  register, so the output port sets the pace (3 bytes per 4 payload chars)
//  results of an accepted character pass through the job queue and the output register
//  reset (synchronous, active low) clears frame state, queue and output valid
//  o_in_stall rises only when the four-entry job queue is full
// ============================================================================
module offset_base64_frame_decoder
    import ob64_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    // front to queue
    logic accept;
    logic push;
    t_job front_job;

    // queue to back
    logic q_full;
    logic q_valid;
    logic pop;
    t_job head_job;

    // accept only while the queue can take whatever this char produces
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // front: delay line, running sum, group of four, frame status
    ob64_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_job    (front_job)
    );

    // decouples char intake from result delivery
    ob64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    // back: one result request per cycle while the output is not stalled, registered
    ob64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

FILE: sv/ob64_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ob64_front
// per-character state: delay line, checksum, group assembly, frame status
// ============================================================================
module ob64_front
    import ob64_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_push,
    output t_job          o_job
);

    logic [PosW-1:0] r_pos, n_pos;
    logic [SumW-1:0] r_sum, n_sum;
    logic [6:0]      r_d0, n_d0, r_d1, n_d1;
    logic [7:0]      r_g0, n_g0, r_g1, n_g1, r_g2, n_g2;
    logic [1:0]      r_fill, n_fill;

    logic [7:0] value;
    logic [6:0] addend;
    logic [6:0] want_hi, want_lo;
    t_job       job;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_g0   = r_g0;
        n_g1   = r_g1;
        n_g2   = r_g2;
        n_fill = r_fill;
        job    = '0;
        value  = {1'b0, r_d1} - 8'(ChOffset);
        addend = (r_pos == PosW'(3) && r_d1 == 7'd127) ? 7'd0 : r_d1;

        // character leaving the delay line is neither checksum char
        if (r_pos >= PosW'(2)) begin
            n_sum = r_sum + {{(SumW-7){1'b0}}, addend};
            if (r_pos >= PosW'(5)) begin
                case (r_fill)
                    2'd0: begin
                        n_g0   = value;
                        n_fill = 2'd1;
                    end
                    2'd1: begin
                        n_g1   = value;
                        n_fill = 2'd2;
                    end
                    2'd2: begin
                        n_g2   = value;
                        n_fill = 2'd3;
                    end
                    default: begin
                        job.has_bytes = 1'b1;
                        job.byte0 = {r_g0[5:0], 2'b00} | {4'b0000, r_g1[7:4]};
                        job.byte1 = {r_g1[3:0], 4'b0000} | {2'b00, r_g2[7:2]};
                        job.byte2 = {r_g2[1:0], 6'b000000} | value;
                        n_fill = 2'd0;
                    end
                endcase
            end
        end

        n_d1 = r_d0;
        n_d0 = i_item.rx_char;
        if (r_pos < PosW'(MaxFrameChars)) begin
            n_pos = r_pos + PosW'(1);
        end

        want_hi = 7'(ChOffset) + {1'b0, n_sum[11:6]};
        want_lo = 7'(ChOffset) + {1'b0, n_sum[5:0]};

        if (i_item.frame_end) begin
            job.has_status = 1'b1;
            if (n_pos < PosW'(5)) begin
                job.status = ST_TOO_SHORT;
            end else if (n_d1 != want_hi || n_d0 != want_lo) begin
                job.status = ST_BAD_SUM;
            end else begin
                job.status = ST_OK;
            end
            n_pos  = '0;
            n_sum  = '0;
            n_d0   = '0;
            n_d1   = '0;
            n_g0   = '0;
            n_g1   = '0;
            n_g2   = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_d0   <= '0;
            r_d1   <= '0;
            r_g0   <= '0;
            r_g1   <= '0;
            r_g2   <= '0;
            r_fill <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_d0   <= n_d0;
            r_d1   <= n_d1;
            r_g0   <= n_g0;
            r_g1   <= n_g1;
            r_g2   <= n_g2;
            r_fill <= n_fill;
        end
    end

    assign o_push = i_accept && (job.has_bytes || job.has_status);
    assign o_job  = job;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.frame_end |=> r_pos == '0 && r_fill == 2'd0 && r_sum == '0)
        else $error("frame state not cleared after frame end");

endmodule
`default_nettype wire

FILE: sv/ob64_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ob64_queue
// short job queue between front and back
// ============================================================================
module ob64_queue
    import ob64_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_head
);

    t_job              r_mem [QueueDepth];
    logic [QPtrW-1:0]  r_wr, r_rd;
    logic [QPtrW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPtrW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPtrW+1)'(1);
            end
        end
    end

    assign o_full  = (r_count == (QPtrW+1)'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: sv/ob64_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ob64_back
// unrolls each job into result requests through an output register
// ============================================================================
module ob64_back
    import ob64_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_out_item  o_out_item
);

    logic [1:0]  r_step;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [2:0]  n_results;
    logic        is_last;
    logic        load;
    t_out_item   res;

    always_comb begin
        n_results = (i_job.has_bytes ? 3'd3 : 3'd0) + {2'b00, i_job.has_status};
        is_last   = ({1'b0, r_step} == n_results - 3'd1);
        res       = '0;
        if (i_job.has_bytes && r_step != 2'd3) begin
            res.kind = KIND_BYTE;
            case (r_step)
                2'd0:    res.data_byte = i_job.byte0;
                2'd1:    res.data_byte = i_job.byte1;
                default: res.data_byte = i_job.byte2;
            endcase
        end else begin
            res.kind   = KIND_STATUS;
            res.status = i_job.status;
        end
        res.last_of_run = is_last;
        load = i_job_valid && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_step      <= is_last ? 2'd0 : r_step + 2'd1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pop       = load && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_step_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 2'd0 |-> i_job_valid && {1'b0, r_step} < n_results)
        else $error("result step outside current job");

endmodule
`default_nettype wire

FILE: tb/offset_base64_frame_decoder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// offset_base64_frame_decoder_test
// self-checking bench for the offset base64 frame decoder: frames of
// characters go in one request at a time, a local decoder model predicts
// every byte and status, and each output request is checked in order
// ============================================================================
module offset_base64_frame_decoder_test
    import ob64_pkg::*;
();

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 12;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    offset_base64_frame_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder model state, mirrors one frame in progress
    // ------------------------------------------------------------------
    logic [PosW-1:0] frame_pos;
    logic [SumW-1:0] frame_sum;
    logic [6:0]      held_chars [2];     // index 0 is the newest
    logic [7:0]      group_vals [3];
    logic [1:0]      group_cnt;
    t_out_item       expected_results [$];

    // run statistics and knobs
    int   errors       = 0;
    int   cycles       = 0;
    int   chars_sent   = 0;
    int   frames_sent  = 0;
    int   bytes_seen   = 0;
    int   status_seen  = 0;
    int   gap_pct      = 0;   // chance of an input gap before a request
    int   stall_pct    = 0;   // chance of an output stall burst per cycle
    bit   quiet        = 1'b0;
    int   stall_left   = 0;
    t_out_item oldest;

    logic [6:0] frame_chars [$];

    function automatic t_out_item make_result(input logic kind, input logic [7:0] data,
                                              input logic [1:0] st);
        t_out_item r;
        r.kind        = kind;
        r.data_byte   = data;
        r.status      = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_frame_state();
        frame_pos     = '0;
        frame_sum     = '0;
        held_chars[0] = '0;
        held_chars[1] = '0;
        group_vals[0] = '0;
        group_vals[1] = '0;
        group_vals[2] = '0;
        group_cnt     = '0;
    endtask

    // predict what one accepted character produces
    task automatic decode_char(input t_in_item req);
        t_out_item  run [$];
        logic [6:0] leaving;
        logic [7:0] v;
        logic [1:0] st;
        int         lidx;
        if (frame_pos >= 2) begin
            leaving = held_chars[1];
            lidx    = int'(frame_pos) - 2;
            // a 127 in the second header slot is not summed
            if (!(lidx == 1 && leaving == 7'd127))
                frame_sum = frame_sum + leaving;
            if (lidx >= 3) begin
                v = {1'b0, leaving} - ChOffset;
                if (group_cnt < 2'd3) begin
                    group_vals[group_cnt] = v;
                    group_cnt++;
                end else begin
                    run.push_back(make_result(KIND_BYTE,
                        (group_vals[0] << 2) | (group_vals[1] >> 4), ST_OK));
                    run.push_back(make_result(KIND_BYTE,
                        ((group_vals[1] & 8'h0f) << 4) | (group_vals[2] >> 2), ST_OK));
                    run.push_back(make_result(KIND_BYTE,
                        ((group_vals[2] & 8'h03) << 6) | v, ST_OK));
                    group_cnt = '0;
                end
            end
        end
        held_chars[1] = held_chars[0];
        held_chars[0] = req.rx_char;
        if (frame_pos < MaxFrameChars)
            frame_pos++;
        if (req.frame_end) begin
            if (frame_pos < 5)
                st = ST_TOO_SHORT;
            else if (int'(held_chars[1]) != ChOffset + int'(frame_sum >> 6) ||
                     int'(held_chars[0]) != ChOffset + int'(frame_sum & 12'h03f))
                st = ST_BAD_SUM;
            else
                st = ST_OK;
            run.push_back(make_result(KIND_STATUS, 8'h00, st));
            clear_frame_state();
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k])
            expected_results.push_back(run[k]);
    endtask

    // one input request; caller stands just after a rising edge
    task automatic send_char(input logic [6:0] ch, input logic fe);
        t_in_item req;
        req.rx_char   = ch;
        req.frame_end = fe;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        decode_char(req);
        chars_sent++;
        if (fe)
            frames_sent++;
    endtask

    // append the two checksum characters to header and payload
    task automatic seal_frame();
        logic [SumW-1:0] s;
        s = '0;
        foreach (frame_chars[k])
            if (!(k == 1 && frame_chars[k] == 7'd127))
                s = s + frame_chars[k];
        frame_chars.push_back(7'(ChOffset + int'(s >> 6)));
        frame_chars.push_back(7'(ChOffset + int'(s & 12'h03f)));
    endtask

    task automatic send_frame();
        foreach (frame_chars[k])
            send_char(frame_chars[k], k == frame_chars.size() - 1);
    endtask

    // header plus n random payload characters, header slot 1 sometimes 127
    task automatic fill_random_frame(input int n_payload);
        frame_chars.delete();
        repeat (3 + n_payload)
            frame_chars.push_back(7'($urandom_range(127)));
        if ($urandom_range(7) == 0)
            frame_chars[1] = 7'd127;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts, none in the quiet part
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // every accepted output request is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual kind %0d byte %0h status %0d",
                         $time, o_out_item.kind, o_out_item.data_byte, o_out_item.status);
                errors++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("kind", 8'(oldest.kind), 8'(o_out_item.kind));
                check_field("data_byte", oldest.data_byte, o_out_item.data_byte);
                check_field("status", 8'(oldest.status), 8'(o_out_item.status));
                check_field("last_of_run", 8'(oldest.last_of_run),
                            8'(o_out_item.last_of_run));
                if (oldest.kind == KIND_STATUS)
                    status_seen++;
                else
                    bytes_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d results still expected", $time,
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // frames of one and four characters report too short
    task automatic test_short_frames();
        gap_pct   = 30;
        stall_pct = 20;
        send_char(7'd127, 1'b1);
        send_char(7'h00, 1'b0);
        send_char(7'h7f, 1'b0);
        send_char(7'h55, 1'b0);
        send_char(7'h2a, 1'b1);
    endtask

    // header only, 127 in the second slot must not be summed
    task automatic test_header_only();
        frame_chars = '{7'h00, 7'h7f, 7'h7f};
        seal_frame();
        send_frame();
    endtask

    // one full group of extreme payload values, good checksum
    task automatic test_full_group();
        frame_chars = '{7'h7f, 7'h00, 7'h2a, 7'h00, 7'h7f, 7'h00, 7'h7f};
        seal_frame();
        send_frame();
    endtask

    // five payload characters leave a dropped partial group, checksum broken
    task automatic test_bad_sum_partial_group();
        frame_chars = '{7'h41, 7'h42, 7'h43, 7'h3d, 7'h7c, 7'h55, 7'h2a, 7'h01};
        seal_frame();
        frame_chars[frame_chars.size() - 1] ^= 7'h01;
        send_frame();
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic test_random_frames();
        int first;
        int pick;
        int n;
        first = chars_sent;
        while (chars_sent - first < 290) begin
            // idling level changes per frame, some frames run with none
            case ($urandom_range(2))
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 10; stall_pct = 8;  end
                default: begin gap_pct = 40; stall_pct = 25; end
            endcase
            pick = $urandom_range(99);
            n    = ($urandom_range(1) == 0) ? 4 * $urandom_range(0, 5)
                                            : $urandom_range(0, 24);
            if (pick < 70) begin
                fill_random_frame(n);
                seal_frame();
            end else if (pick < 80) begin
                fill_random_frame(n);
                seal_frame();
                frame_chars[$urandom_range(frame_chars.size() - 1)] ^=
                    7'($urandom_range(1, 127));
            end else if (pick < 90) begin
                fill_random_frame(0);
                frame_chars = frame_chars[0:$urandom_range(0, 2)];
                if ($urandom_range(1) == 0)
                    frame_chars.push_back(7'($urandom_range(127)));
            end else begin
                fill_random_frame($urandom_range(2, 9));
            end
            send_frame();
        end
    endtask

    // closing stretch with neither side idling
    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (3) begin
            fill_random_frame(8);
            seal_frame();
            send_frame();
        end
        send_char(7'h3d, 1'b1);
    endtask

    initial begin
        clear_frame_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_header_only();
        test_full_group();
        test_bad_sum_partial_group();
        test_random_frames();
        test_back_to_back();

        // last request was taken at the edge just passed
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("sent %0d characters in %0d frames, short, broken and well-formed ones",
                 chars_sent, frames_sent);
        $display("checked %0d decoded bytes and %0d frame status results, %0d mismatches",
                 bytes_seen, status_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
